FILE: rtl/core/gf2mnc_pkg.sv
// Shared types, codes and helpers for the GF(2) nibble codec.
// No dependencies; imported by gf2_matrix_nibble_codec_top.
`timescale 1ns / 1ps
`default_nettype none

package gf2mnc_pkg;

    localparam int NUM_ROWS = 4;
    localparam int COLS     = 8;
    localparam int COL_W    = 3;

    typedef logic [NUM_ROWS-1:0][COLS-1:0] key_t;
    typedef logic [COL_W-1:0]              col_t;

    typedef enum logic
    {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        REG_KEY_ROW0 = 2'd0,
        REG_KEY_ROW1 = 2'd1,
        REG_KEY_ROW2 = 2'd2,
        REG_KEY_ROW3 = 2'd3
    } reg_idx_t;

    // Nibble bit 3 picks row 0, nibble bit 0 picks row 3.
    function automatic logic [COLS-1:0] mul_nibble(input key_t key, input logic [3:0] nib);
        logic [COLS-1:0] acc;
        acc = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (nib[3-r])
            begin
                acc = acc ^ key[r];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gf2_matrix_nibble_codec_top.sv
// Top level of the GF(2) 4x8 generator matrix nibble codec.
// Depends on gf2mnc_pkg for key, kind and register index types.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken in every clock cycle (busy is always low) and its result
// appears on the done strobe after passing through the input register and
// then the XOR and column-select logic into the result register. Encode gives
// the codes of the high and low nibbles; decode gives the rebuilt byte in
// out_high, or key_error with zero data when the key lacks an identity column.
// Done is raised for exactly one cycle per result, and the result registers
// keep the data until the next item. Key rows are written through the cfg
// port, which is always ready; write them only while no item is in flight.
module gf2_matrix_nibble_codec_top
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  kind,
    input  wire logic [7:0]            first_byte,
    input  wire logic [7:0]            second_byte,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire gf2mnc_pkg::reg_idx_t  cfg_index,
    input  wire logic [7:0]            cfg_data,
    output logic                       done,
    output logic [7:0]                 out_high,
    output logic [7:0]                 out_low,
    output logic                       key_error
);

    import gf2mnc_pkg::*;

    key_t            key_reg;
    logic            in_valid_reg;
    kind_t           in_kind_reg;
    logic [7:0]      in_b1_reg;
    logic [7:0]      in_b2_reg;

    logic            out_valid_reg;
    logic [7:0]      out_high_reg;
    logic [7:0]      out_low_reg;
    logic            key_error_reg;

    logic [7:0]      out_high_next;
    logic [7:0]      out_low_next;
    logic            key_error_next;

    col_t [NUM_ROWS-1:0] pos;
    logic [NUM_ROWS-1:0] found;
    logic [NUM_ROWS-1:0] colv;
    logic [7:0]          dec_byte;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Key rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_ROW0: key_reg[0] <= cfg_data;
                REG_KEY_ROW1: key_reg[1] <= cfg_data;
                REG_KEY_ROW2: key_reg[2] <= cfg_data;
                REG_KEY_ROW3: key_reg[3] <= cfg_data;
                default:      key_reg    <= key_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_kind_reg <= kind_t'(kind);
            in_b1_reg   <= first_byte;
            in_b2_reg   <= second_byte;
        end
    end

    // Find identity columns; scan in column order so the last match wins
    always_comb
    begin
        pos   = '0;
        found = '0;
        colv  = '0;
        for (int c = 0; c < COLS; c++)
        begin
            for (int k = 0; k < NUM_ROWS; k++)
            begin
                colv[k] = key_reg[k][COL_W'(COLS - 1 - c)];
            end
            for (int k = 0; k < NUM_ROWS; k++)
            begin
                if (colv == (NUM_ROWS'(1) << k))
                begin
                    pos[k]   = COL_W'(c);
                    found[k] = 1'b1;
                end
            end
        end
    end

    // Column c sits at bit 7-c, which is ~c on three bits
    always_comb
    begin
        dec_byte = '0;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            dec_byte[7-k] = in_b1_reg[~pos[k]];
            dec_byte[3-k] = in_b2_reg[~pos[k]];
        end
    end

    always_comb
    begin
        out_high_next  = '0;
        out_low_next   = '0;
        key_error_next = 1'b0;
        case (in_kind_reg)
            KIND_ENCODE:
            begin
                out_high_next = mul_nibble(key_reg, in_b1_reg[7:4]);
                out_low_next  = mul_nibble(key_reg, in_b1_reg[3:0]);
            end
            KIND_DECODE:
            begin
                if (&found)
                begin
                    out_high_next = dec_byte;
                end
                else
                begin
                    key_error_next = 1'b1;
                end
            end
            default:
            begin
                out_high_next = '0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_high_reg  <= out_high_next;
            out_low_reg   <= out_low_next;
            key_error_reg <= key_error_next;
        end
    end

    assign done      = out_valid_reg;
    assign out_high  = out_high_reg;
    assign out_low   = out_low_reg;
    assign key_error = key_error_reg;

    // Every accepted beat yields a result on done, through the input and result registers
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> !done)
        else $error("result strobe without an accepted beat");

    a_key_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && key_error) |-> (out_high == 8'd0 && out_low == 8'd0))
        else $error("key error with non-zero data");

    a_error_only_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_kind_reg == KIND_ENCODE) |=> !key_error)
        else $error("key error raised on encode");

endmodule

`default_nettype wire
